/* design/kcc_lock_pkg.sv */
// ----------------------------------------------------------------------------
// kcc_lock_pkg
// Shared types and constants for the keypad code-change lock.
// ----------------------------------------------------------------------------
package kcc_lock_pkg;

  localparam int CODE_LENGTH = 4;
  localparam int CODE_W      = 4 * CODE_LENGTH;
  localparam int CNT_W       = $clog2(CODE_LENGTH + 1);
  localparam int IDX_W       = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CODE_LENGTH - 1);

  localparam logic [7:0] KEY_DIGIT_LO  = 8'h30;  // '0'
  localparam logic [7:0] KEY_DIGIT_HI  = 8'h39;  // '9'
  localparam logic [7:0] KEY_BACKSPACE = 8'h42;  // 'B'

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_MASK  = 2'd1;
  localparam logic [1:0] ACT_BLANK = 2'd2;

  localparam logic [2:0] ST_ENTERING    = 3'd0;
  localparam logic [2:0] ST_WRONG_OLD   = 3'd1;
  localparam logic [2:0] ST_NEW_REQ     = 3'd2;
  localparam logic [2:0] ST_CONFIRM_REQ = 3'd3;
  localparam logic [2:0] ST_UPDATED     = 3'd4;
  localparam logic [2:0] ST_MISMATCH    = 3'd5;

  localparam logic [1:0] PH_CODE_OLD     = 2'd0;
  localparam logic [1:0] PH_CODE_NEW     = 2'd1;
  localparam logic [1:0] PH_CODE_CONFIRM = 2'd2;

  typedef enum logic [2:0] {
    PH_OLD     = 3'b001,
    PH_NEW     = 3'b010,
    PH_CONFIRM = 3'b100
  } phase_t;

  typedef struct packed {
    logic [1:0] phase_now;
    logic [2:0] session_status;
    logic [1:0] echo_position;
    logic [1:0] echo_action;
  } result_t;

endpackage

/* design/keypad_code_change_lock_core.sv */
// ----------------------------------------------------------------------------
// keypad_code_change_lock_core
// Runs an old-code / new-code / confirm session from a stream of key items.
// ----------------------------------------------------------------------------
// The key item is held in the input register and the result item in the
// result register; the session state is updated as an item moves between them.
// Throughput: one key item per cycle while the receiver takes result items;
// out_tready low holds the result register and stalls the input register.
// Reset (rst_n low, synchronous) empties both stages, returns the session
// to the old-code phase and sets the stored code to all zero digits.
module keypad_code_change_lock_core
  import kcc_lock_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] key_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [1:0] echo_action, [3:2] echo_position,
                                  // [6:4] session_status, [8:7] phase_now
);

  logic              in_v_r;
  logic [7:0]        key_r;
  logic              out_v_r;
  result_t           res_r;
  result_t           res_nxt;
  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [3:0]        digits_r [CODE_LENGTH];
  logic [CODE_W-1:0] pending_r;
  logic [CODE_W-1:0] stored_r, stored_nxt;

  logic              advance;
  logic              is_digit, is_back;
  logic [3:0]        digit_val;
  logic [CODE_W-1:0] code;
  logic [CNT_W+1:0]  cnt_ext, cnt_dec_ext;
  logic [CNT_W-1:0]  cnt_dec;
  logic [1:0]        phase_code;

  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, res_r};

  assign is_digit  = (key_r >= KEY_DIGIT_LO) && (key_r <= KEY_DIGIT_HI);
  assign is_back   = (key_r == KEY_BACKSPACE);
  assign digit_val = 4'(key_r - KEY_DIGIT_LO);
  assign cnt_dec   = cnt_r - CNT_W'(1);
  assign cnt_ext     = {2'b00, cnt_r};
  assign cnt_dec_ext = {2'b00, cnt_dec};

  // The entry with the incoming digit in place, first digit in the top nibble.
  always_comb begin
    for (int i = 0; i < CODE_LENGTH; i++) begin
      code[CODE_W-1-4*i -: 4] = (cnt_r == CNT_W'(i)) ? digit_val : digits_r[i];
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    stored_nxt = stored_r;
    res_nxt    = '0;
    res_nxt.session_status = ST_ENTERING;
    if (is_digit) begin
      res_nxt.echo_action   = ACT_MASK;
      res_nxt.echo_position = cnt_ext[1:0];
      cnt_nxt               = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_LAST) begin
        cnt_nxt = '0;
        unique case (phase_r)
          PH_NEW: begin
            phase_nxt              = PH_CONFIRM;
            res_nxt.session_status = ST_CONFIRM_REQ;
          end
          PH_CONFIRM: begin
            phase_nxt = PH_OLD;
            if (code == pending_r) begin
              stored_nxt             = code;
              res_nxt.session_status = ST_UPDATED;
            end else begin
              res_nxt.session_status = ST_MISMATCH;
            end
          end
          default: begin
            if (code == stored_r) begin
              phase_nxt              = PH_NEW;
              res_nxt.session_status = ST_NEW_REQ;
            end else begin
              phase_nxt              = PH_OLD;
              res_nxt.session_status = ST_WRONG_OLD;
            end
          end
        endcase
      end
    end else if (is_back && (cnt_r != '0)) begin
      cnt_nxt               = cnt_dec;
      res_nxt.echo_action   = ACT_BLANK;
      res_nxt.echo_position = cnt_dec_ext[1:0];
    end
    unique case (phase_nxt)
      PH_NEW:     phase_code = PH_CODE_NEW;
      PH_CONFIRM: phase_code = PH_CODE_CONFIRM;
      default:    phase_code = PH_CODE_OLD;
    endcase
    res_nxt.phase_now = phase_code;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      phase_r  <= PH_OLD;
      cnt_r    <= '0;
      stored_r <= '0;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (advance) begin
        out_v_r  <= 1'b1;
        phase_r  <= phase_nxt;
        cnt_r    <= cnt_nxt;
        stored_r <= stored_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers: the digit store is always rewritten before it is read.
  always_ff @(posedge clk) begin
    if (in_tready) begin
      key_r <= in_tdata;
    end
    if (advance) begin
      res_r <= res_nxt;
      if (is_digit) begin
        digits_r[cnt_r[IDX_W-1:0]] <= digit_val;
        if ((cnt_r == CNT_LAST) && (phase_r == PH_NEW)) begin
          pending_r <= code;
        end
      end
    end
  end

endmodule

/* tb/keypad_code_change_lock_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_code_change_lock_core_test
// Drives key items into the code-change lock and checks every echo item
// against a session tracker that follows the old, new and confirm phases.
// ----------------------------------------------------------------------------
module keypad_code_change_lock_core_test;
  import kcc_lock_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int TARGET_KEYS  = 1050;
  localparam int QUIET_KEYS   = 900;
  localparam int HOLD_KEYS    = 300;
  localparam int HOLD_CYCLES  = 200;

  // Follows the lock session and keeps the echo items still to arrive.
  class keypad_lock_tracker;
    logic [1:0]        phase;
    int                count;
    logic [3:0]        digits [CODE_LENGTH];
    logic [CODE_W-1:0] pending_code;
    logic [CODE_W-1:0] stored_code;
    result_t           expected_echoes [$];
    int                errors;

    function new();
      phase        = PH_CODE_OLD;
      count        = 0;
      pending_code = '0;
      stored_code  = '0;
      errors       = 0;
      foreach (digits[i]) digits[i] = '0;
    endfunction

    function void note_key(logic [7:0] key);
      result_t           r;
      logic [CODE_W-1:0] code;
      r = '0;
      r.session_status = ST_ENTERING;
      if (key >= KEY_DIGIT_LO && key <= KEY_DIGIT_HI) begin
        digits[count]   = 4'(key - KEY_DIGIT_LO);
        r.echo_action   = ACT_MASK;
        r.echo_position = 2'(count);
        count++;
        if (count == CODE_LENGTH) begin
          // First digit entered ends up in the most significant nibble.
          code = '0;
          for (int i = 0; i < CODE_LENGTH; i++) code = (code << 4) | CODE_W'(digits[i]);
          count = 0;
          case (phase)
            PH_CODE_NEW: begin
              pending_code     = code;
              phase            = PH_CODE_CONFIRM;
              r.session_status = ST_CONFIRM_REQ;
            end
            PH_CODE_CONFIRM: begin
              if (code == pending_code) begin
                stored_code      = code;
                r.session_status = ST_UPDATED;
              end else begin
                r.session_status = ST_MISMATCH;
              end
              phase = PH_CODE_OLD;
            end
            default: begin
              if (code == stored_code) begin
                phase            = PH_CODE_NEW;
                r.session_status = ST_NEW_REQ;
              end else begin
                r.session_status = ST_WRONG_OLD;
              end
            end
          endcase
        end
      end else if (key == KEY_BACKSPACE && count > 0) begin
        count--;
        digits[count]   = '0;
        r.echo_action   = ACT_BLANK;
        r.echo_position = 2'(count);
      end
      r.phase_now = phase;
      expected_echoes.push_back(r);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_echo(logic [15:0] data);
      result_t got;
      result_t want;
      got = data[$bits(result_t)-1:0];
      if (expected_echoes.size() == 0) begin
        errors++;
        $display("%0t: unexpected echo item, expected none, got %h", $time, data);
      end else begin
        want = expected_echoes.pop_front();
        compare_field("echo_action", want.echo_action, got.echo_action);
        compare_field("echo_position", want.echo_position, got.echo_position);
        compare_field("session_status", want.session_status, got.session_status);
        compare_field("phase_now", want.phase_now, got.phase_now);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;

  keypad_lock_tracker tracker;
  int                 keys_sent;
  bit                 quiet;
  bit                 hold_req;
  bit                 hold_done;
  logic [7:0]         directed_keys [25];

  keypad_code_change_lock_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_echo(out_tdata);
  end

  // Receiver: random hold-off bursts, one long hold-off on request, none at the end.
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] ignored_key();
    logic [7:0] k;
    do begin
      k = 8'($urandom_range(0, 255));
    end while ((k >= KEY_DIGIT_LO && k <= KEY_DIGIT_HI) || k == KEY_BACKSPACE);
    return k;
  endfunction

  function automatic logic [CODE_W-1:0] random_code();
    logic [CODE_W-1:0] code;
    code = '0;
    for (int i = 0; i < CODE_LENGTH; i++) code = (code << 4) | CODE_W'($urandom_range(0, 9));
    return code;
  endfunction

  task automatic send_key(input logic [7:0] key);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom_range(0, 255));
      repeat ($urandom_range(1, 5) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= key;
    do @(posedge clk); while (!in_tready);
    tracker.note_key(key);
    keys_sent++;
    if (keys_sent > QUIET_KEYS) quiet = 1'b1;
    if (keys_sent > HOLD_KEYS && !hold_done) begin
      hold_done = 1'b1;
      hold_req  = 1'b1;
    end
  endtask

  // Types a whole code; when noisy, stray keys and corrected typos are mixed in.
  task automatic send_code(input logic [CODE_W-1:0] code, input bit noisy);
    logic [3:0] d;
    for (int i = 0; i < CODE_LENGTH; i++) begin
      d = code[CODE_W-1-4*i -: 4];
      if (noisy && $urandom_range(0, 4) == 0) send_key(ignored_key());
      if (noisy && i < CODE_LENGTH - 1 && $urandom_range(0, 5) == 0) begin
        send_key(KEY_DIGIT_LO + 8'($urandom_range(0, 9)));
        send_key(KEY_BACKSPACE);
      end
      if (noisy && i > 0 && $urandom_range(0, 5) == 0) begin
        send_key(KEY_BACKSPACE);
        send_key(KEY_DIGIT_LO + 8'(code[CODE_W+3-4*i -: 4]));
      end
      send_key(KEY_DIGIT_LO + 8'(d));
    end
  endtask

  initial begin
    int                kind;
    bit                noisy;
    logic [CODE_W-1:0] new_code;

    tracker    = new();
    keys_sent  = 0;
    quiet      = 1'b0;
    hold_req   = 1'b0;
    hold_done  = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;

    // Neighbours of the digit and backspace codes are all ignored keys.
    directed_keys = '{8'h00, 8'hFF, KEY_BACKSPACE, KEY_DIGIT_LO - 8'd1,
                      KEY_DIGIT_HI + 8'd1, KEY_BACKSPACE - 8'd1, KEY_BACKSPACE + 8'd1,
                      KEY_DIGIT_HI, KEY_BACKSPACE,
                      KEY_DIGIT_LO, KEY_DIGIT_LO, KEY_DIGIT_LO, KEY_DIGIT_LO,
                      KEY_DIGIT_HI, KEY_DIGIT_HI, KEY_DIGIT_HI, KEY_DIGIT_HI,
                      KEY_DIGIT_HI, KEY_DIGIT_HI, KEY_DIGIT_HI, KEY_DIGIT_HI,
                      KEY_DIGIT_LO, KEY_DIGIT_LO, KEY_DIGIT_LO, KEY_DIGIT_LO};

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_keys[i]) send_key(directed_keys[i]);

    while (keys_sent < TARGET_KEYS) begin
      kind  = $urandom_range(0, 9);
      noisy = ($urandom_range(0, 2) == 0);
      if (kind <= 5) begin
        // Bring the session back to the start of an old-code entry first.
        while (tracker.count != 0) send_key(KEY_BACKSPACE);
        while (tracker.phase != PH_CODE_OLD) send_code(random_code(), 1'b0);
        send_code(tracker.stored_code, noisy);
        new_code = random_code();
        send_code(new_code, noisy);
        if ($urandom_range(0, 3) == 0) send_code(random_code(), noisy);
        else send_code(new_code, noisy);
      end else if (kind <= 7) begin
        send_code(random_code(), noisy);
      end else if (kind == 8) begin
        repeat ($urandom_range(1, 6)) send_key(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, CODE_LENGTH - 1)) send_key(KEY_DIGIT_LO + 8'($urandom_range(0, 9)));
        repeat ($urandom_range(1, CODE_LENGTH + 1)) send_key(KEY_BACKSPACE);
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (tracker.expected_echoes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (tracker.errors == 0 && tracker.expected_echoes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/kcc_lock_pkg.sv
design/keypad_code_change_lock_core.sv
tb/keypad_code_change_lock_core_test.sv
